FILE: hw/rtl/rlm_pkg.sv
// ----------------------------------------------------------------------------
// Radio level meter package
// Shared widths, codes, reading descriptors and the multiplier operand size.
// ----------------------------------------------------------------------------
package rlm_pkg;

   // Fixed number formats
   localparam int SAMPLE_BITS   = 16;
   localparam int EMA_FRAC_BITS = 20;
   localparam int DB_FRAC_BITS  = 6;
   localparam int DB_SHIFT      = 32 - DB_FRAC_BITS;
   localparam int LOG_FRAC      = 16;
   localparam int MANT_W        = 31;
   localparam int LOG_K         = 197283;
   localparam int BUF_LEN_DEF   = 4096;

   // Transmit average storage, split in two halves for the decay product
   localparam int EMA_W     = 52;
   localparam int EMA_SPLIT = 26;
   localparam int EMA_CNT   = 5;

   // Shared multiplier operand and product widths
   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;

   // Log scale offsets (power of two of full scale)
   localparam int SCALE_PEAK = SAMPLE_BITS - 1;
   localparam int SCALE_POW  = 2 * (SAMPLE_BITS - 1);
   localparam int SCALE_GAIN = 16;
   localparam int SCALE_EMA  = EMA_FRAC_BITS + 2 * (SAMPLE_BITS - 1);

   // Readings for a zero operand
   localparam logic signed [15:0] DB_FLOOR_200 = 16'(-200 * (1 << DB_FRAC_BITS));
   localparam logic signed [15:0] DB_FLOOR_320 = 16'(-320 * (1 << DB_FRAC_BITS));
   localparam logic signed [15:0] DB_CEIL_160  = 16'(160 * (1 << DB_FRAC_BITS));

   // Reset values of the configuration and the strength average
   localparam logic [15:0]        RX_AVG_COEF_RST = 16'd3277;
   localparam logic [15:0]        TX_EMA_COEF_RST = 16'd524;
   localparam logic signed [15:0] AVG_DB_RST      = DB_FLOOR_200;

   // Configuration register indexes
   localparam logic CSR_RX_AVG_COEF = 1'b0;
   localparam logic CSR_TX_EMA_COEF = 1'b1;

   // Meter kinds of the input samples
   localparam logic [3:0] KIND_RX_PRE  = 4'd0;
   localparam logic [3:0] KIND_RX_FILT = 4'd1;
   localparam logic [3:0] KIND_RX_AGC  = 4'd2;
   localparam logic [3:0] KIND_MIC     = 4'd3;
   localparam logic [3:0] KIND_PWR     = 4'd4;
   localparam logic [3:0] KIND_ALC     = 4'd5;
   localparam logic [3:0] KIND_EQ      = 4'd6;
   localparam logic [3:0] KIND_LEVELER = 4'd7;
   localparam logic [3:0] KIND_COMP    = 4'd8;

   // Meter identifiers of the readings
   localparam logic [3:0] ID_ADC_RE   = 4'd0;
   localparam logic [3:0] ID_ADC_IM   = 4'd1;
   localparam logic [3:0] ID_STRENGTH = 4'd2;
   localparam logic [3:0] ID_AVG_STR  = 4'd3;
   localparam logic [3:0] ID_AGC_GAIN = 4'd4;
   localparam logic [3:0] ID_MIC      = 4'd5;
   localparam logic [3:0] ID_PWR      = 4'd6;
   localparam logic [3:0] ID_ALC      = 4'd7;
   localparam logic [3:0] ID_ALC_GAIN = 4'd8;
   localparam logic [3:0] ID_EQ       = 4'd9;
   localparam logic [3:0] ID_LEVELER  = 4'd10;
   localparam logic [3:0] ID_LVL_GAIN = 4'd11;
   localparam logic [3:0] ID_COMP     = 4'd12;

   // Operand sources of a reading
   localparam logic [2:0] SRC_PEAK_I = 3'd0;
   localparam logic [2:0] SRC_PEAK_Q = 3'd1;
   localparam logic [2:0] SRC_SUM    = 3'd2;
   localparam logic [2:0] SRC_GAIN   = 3'd3;
   localparam logic [2:0] SRC_EMA    = 3'd4;
   localparam logic [2:0] SRC_AVG    = 3'd5;
   localparam logic [2:0] SRC_DIV    = 3'd6;

   // One reading: what to compute and how to tag it
   typedef struct packed {
      logic [3:0]        id;
      logic [2:0]        src;
      logic [5:0]        scale;
      logic              dbl;
      logic              neg;
      logic signed [15:0] zero_val;
      logic              is_last;
   } rlm_rd_type;

   // Reading descriptor for a buffer kind and reading slot
   function automatic rlm_rd_type rd_desc(input logic [3:0] kind, input logic rd);
      rlm_rd_type d;
      d.id       = ID_COMP;
      d.src      = SRC_EMA;
      d.scale    = 6'(SCALE_EMA);
      d.dbl      = 1'b0;
      d.neg      = 1'b1;
      d.zero_val = DB_CEIL_160;
      d.is_last  = 1'b1;
      unique case (kind)
         KIND_RX_PRE: begin
            d.id       = rd ? ID_ADC_IM : ID_ADC_RE;
            d.src      = rd ? SRC_PEAK_Q : SRC_PEAK_I;
            d.scale    = 6'(SCALE_PEAK);
            d.dbl      = 1'b1;
            d.neg      = 1'b0;
            d.zero_val = DB_FLOOR_200;
            d.is_last  = rd;
         end
         KIND_RX_FILT: begin
            d.id       = rd ? ID_AVG_STR : ID_STRENGTH;
            d.src      = rd ? SRC_AVG : SRC_SUM;
            d.scale    = 6'(SCALE_POW);
            d.neg      = 1'b0;
            d.zero_val = DB_FLOOR_200;
            d.is_last  = rd;
         end
         KIND_RX_AGC: begin
            d.id       = ID_AGC_GAIN;
            d.src      = SRC_GAIN;
            d.scale    = 6'(SCALE_GAIN);
            d.dbl      = 1'b1;
            d.neg      = 1'b0;
            d.zero_val = DB_FLOOR_200;
         end
         KIND_MIC: begin
            d.id = ID_MIC;
         end
         KIND_PWR: begin
            d.id  = ID_PWR;
            d.src = SRC_DIV;
            d.neg = 1'b0;
         end
         KIND_ALC, KIND_LEVELER: begin
            d.is_last = rd;
            d.id      = (kind == KIND_ALC) ? (rd ? ID_ALC_GAIN : ID_ALC)
                                           : (rd ? ID_LVL_GAIN : ID_LEVELER);
            if (rd) begin
               d.src      = SRC_GAIN;
               d.scale    = 6'(SCALE_GAIN);
               d.dbl      = 1'b1;
               d.neg      = 1'b0;
               d.zero_val = DB_FLOOR_320;
            end
         end
         KIND_EQ: begin
            d.id = ID_EQ;
         end
         default: begin
            d.id = ID_COMP;
         end
      endcase
      return d;
   endfunction

endpackage

FILE: hw/rtl/radio_level_meter_db_top.sv
// ----------------------------------------------------------------------------
// Radio level meter, dB readings
// Tracks peaks, power and transmit averages of IQ buffers and emits dB
// and power readings at each buffer end through one shared multiplier.
// ----------------------------------------------------------------------------
//   Channel  Direction  Content
//   req_     in         tdata = sample_re, sample_im, gain; tuser = kind; tlast = last
//   rsp_     out        tdata = value; tuser = meter_id; tlast = last_result
//   csr_     in         write enable, register index, 16-bit data
//
// A sample that ends no buffer is spent on the multiplier for |x|^2 and, for a
// transmit kind, the average update. A buffer end adds per dB reading a
// leading-one search over the 52-bit operand, the log2 squarings and the dB
// scaling, and per power reading a restoring divide of the sum by the count.
// Reset is synchronous; it clears the buffer state and the transmit averages
// at once and sets the strength average to its floor. A result waits in the
// output register; the next reading stalls until it is taken.
module radio_level_meter_db_top #(
   parameter int BUF_LEN = rlm_pkg::BUF_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // sample_re[15:0], sample_im[31:16], gain[55:32]
   input  logic [3:0]  req_tuser,   // kind
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // value
   output logic [3:0]  rsp_tuser,   // meter_id
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [15:0] csr_wdata
);

   localparam int CNT_W  = $clog2(BUF_LEN + 1);
   localparam int SUM_W  = 2 * rlm_pkg::SAMPLE_BITS + $clog2(BUF_LEN);
   localparam int LV_W   = (SUM_W > rlm_pkg::EMA_W) ? SUM_W : rlm_pkg::EMA_W;
   localparam int E_W    = $clog2(LV_W);
   localparam int D_W    = E_W + rlm_pkg::LOG_FRAC + 2;
   localparam int IT_W   = $clog2(SUM_W);
   localparam int MUL_W  = rlm_pkg::MUL_W;
   localparam int PROD_W = rlm_pkg::PROD_W;
   localparam int EMA_W  = rlm_pkg::EMA_W;

   // Sequencer states
   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_SQI  = 5'd1;
   localparam logic [4:0] ST_SQQ  = 5'd2;
   localparam logic [4:0] ST_PSUM = 5'd3;
   localparam logic [4:0] ST_EHI  = 5'd4;
   localparam logic [4:0] ST_ELO  = 5'd5;
   localparam logic [4:0] ST_EPC  = 5'd6;
   localparam logic [4:0] ST_EUPD = 5'd7;
   localparam logic [4:0] ST_CHK  = 5'd8;
   localparam logic [4:0] ST_LSEL = 5'd9;
   localparam logic [4:0] ST_NORM = 5'd10;
   localparam logic [4:0] ST_SQ   = 5'd11;
   localparam logic [4:0] ST_SQW  = 5'd12;
   localparam logic [4:0] ST_DBM  = 5'd13;
   localparam logic [4:0] ST_DBK  = 5'd14;
   localparam logic [4:0] ST_DBR  = 5'd15;
   localparam logic [4:0] ST_AVG1 = 5'd16;
   localparam logic [4:0] ST_AVG2 = 5'd17;
   localparam logic [4:0] ST_AVG3 = 5'd18;
   localparam logic [4:0] ST_DIV  = 5'd19;
   localparam logic [4:0] ST_EMIT = 5'd20;

   logic [4:0]               state_ff, state_in;
   logic [3:0]               kind_ff, kind_in;
   logic                     last_ff, last_in;
   logic [15:0]              ar_ff, ar_in, ai_ff, ai_in;
   logic [23:0]              gain_ff, gain_in;
   logic [15:0]              peak_i_ff, peak_i_in, peak_q_ff, peak_q_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [15:0]       avg_ff, avg_in;
   logic [EMA_W-1:0]         ema_ff [rlm_pkg::EMA_CNT];
   logic [EMA_W-1:0]         ema_in [rlm_pkg::EMA_CNT];
   logic [31:0]              p_ff, p_in;
   logic [EMA_W-1:0]         dec_ff, dec_in;
   logic signed [PROD_W-1:0] acc_ff, acc_in;
   logic [LV_W-1:0]          v_ff, v_in;
   logic [E_W-1:0]           e_ff, e_in;
   logic [rlm_pkg::MANT_W-1:0] m_ff, m_in;
   logic [15:0]              f_ff, f_in;
   logic [IT_W-1:0]          it_ff, it_in;
   logic signed [D_W-1:0]    d_ff, d_in;
   logic signed [31:0]       res_ff, res_in;
   logic                     rd_ff, rd_in;
   logic [CNT_W-1:0]         rem_ff, rem_in;
   logic [SUM_W-1:0]         q_ff, q_in;
   logic [15:0]              rx_coef_ff, tx_coef_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [3:0]               rsp_id_ff, rsp_id_in;
   logic [31:0]              rsp_value_ff, rsp_value_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_ff;

   rlm_pkg::rlm_rd_type      desc;
   logic [2:0]               ema_idx;
   logic [EMA_W-1:0]         ema_cur;
   logic signed [15:0]       s_re, s_im;

   assign desc    = rlm_pkg::rd_desc(kind_ff, rd_ff);
   assign ema_idx = (kind_ff == rlm_pkg::KIND_MIC) ? 3'd0 : 3'(kind_ff - 4'd4);
   assign ema_cur = ema_ff[ema_idx];
   assign s_re    = req_tdata[15:0];
   assign s_im    = req_tdata[31:16];

   // Shared multiplier
   rlm_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   // Multiplier operand selection per step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_SQI: begin
            mul_a = MUL_W'(ar_ff);
            mul_b = MUL_W'(ar_ff);
         end
         ST_SQQ: begin
            mul_a = MUL_W'(ai_ff);
            mul_b = MUL_W'(ai_ff);
         end
         ST_EHI: begin
            mul_a = MUL_W'(ema_cur[EMA_W-1:rlm_pkg::EMA_SPLIT]);
            mul_b = MUL_W'(tx_coef_ff);
         end
         ST_ELO: begin
            mul_a = MUL_W'(ema_cur[rlm_pkg::EMA_SPLIT-1:0]);
            mul_b = MUL_W'(tx_coef_ff);
         end
         ST_EPC: begin
            mul_a = MUL_W'(p_ff);
            mul_b = MUL_W'(tx_coef_ff);
         end
         ST_SQ: begin
            mul_a = MUL_W'(m_ff);
            mul_b = MUL_W'(m_ff);
         end
         ST_DBK: begin
            mul_a = MUL_W'(d_ff);
            mul_b = MUL_W'(rlm_pkg::LOG_K);
         end
         ST_AVG1: begin
            mul_a = MUL_W'(avg_ff);
            mul_b = MUL_W'(17'h10000 - {1'b0, rx_coef_ff});
         end
         ST_AVG2: begin
            mul_a = MUL_W'(res_ff);
            mul_b = MUL_W'(rx_coef_ff);
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   // Sequencer and datapath next values
   always_comb begin
      logic [16:0]              abs_re, abs_im;
      logic [31:0]              psq;
      logic [31:0]              t;
      logic [LV_W-1:0]          src_val;
      logic signed [PROD_W-1:0] x;
      logic signed [PROD_W-1:0] r;
      logic signed [PROD_W-1:0] a;
      logic [CNT_W:0]           sh;
      logic [CNT_W+1:0]         diff;

      state_in     = state_ff;
      kind_in      = kind_ff;
      last_in      = last_ff;
      ar_in        = ar_ff;
      ai_in        = ai_ff;
      gain_in      = gain_ff;
      peak_i_in    = peak_i_ff;
      peak_q_in    = peak_q_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      avg_in       = avg_ff;
      ema_in       = ema_ff;
      p_in         = p_ff;
      dec_in       = dec_ff;
      acc_in       = acc_ff;
      v_in         = v_ff;
      e_in         = e_ff;
      m_in         = m_ff;
      f_in         = f_ff;
      it_in        = it_ff;
      d_in         = d_ff;
      res_in       = res_ff;
      rd_in        = rd_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_id_in    = rsp_id_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;

      abs_re  = s_re[15] ? 17'(-$signed({s_re[15], s_re})) : {1'b0, s_re};
      abs_im  = s_im[15] ? 17'(-$signed({s_im[15], s_im})) : {1'b0, s_im};
      psq     = p_ff + prod_ff[31:0];
      t       = prod_ff[61:30];
      x       = desc.dbl ? (prod_ff <<< 1) : prod_ff;
      r       = (x + (PROD_W'(1) <<< (rlm_pkg::DB_SHIFT - 1))) >>> rlm_pkg::DB_SHIFT;
      a       = (acc_ff + prod_ff + PROD_W'(32768)) >>> 16;
      sh      = {rem_ff, q_ff[SUM_W-1]};
      diff    = {1'b0, sh} - {2'b00, count_ff};

      unique case (desc.src)
         rlm_pkg::SRC_PEAK_I: src_val = LV_W'(peak_i_ff);
         rlm_pkg::SRC_PEAK_Q: src_val = LV_W'(peak_q_ff);
         rlm_pkg::SRC_SUM:    src_val = LV_W'(sum_ff);
         rlm_pkg::SRC_GAIN:   src_val = LV_W'(gain_ff);
         default:             src_val = LV_W'(ema_cur);
      endcase

      unique case (state_ff)
         // Take a sample and update the peaks at once; an unknown kind only clears the buffer state on its last sample
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in = req_tuser;
               last_in = req_tlast;
               ar_in   = abs_re[15:0];
               ai_in   = abs_im[15:0];
               gain_in = req_tdata[55:32];
               if (req_tuser > rlm_pkg::KIND_COMP) begin
                  if (req_tlast) begin
                     peak_i_in = '0;
                     peak_q_in = '0;
                     sum_in    = '0;
                     count_in  = '0;
                  end
               end else begin
                  if (abs_re[15:0] > peak_i_ff) peak_i_in = abs_re[15:0];
                  if (abs_im[15:0] > peak_q_ff) peak_q_in = abs_im[15:0];
                  state_in = ST_SQI;
               end
            end
         end
         ST_SQI: begin
            state_in = ST_SQQ;
         end
         ST_SQQ: begin
            p_in     = prod_ff[31:0];
            state_in = ST_PSUM;
         end
         // Sample power into the buffer sums
         ST_PSUM: begin
            p_in = psq;
            if (count_ff < CNT_W'(BUF_LEN)) begin
               sum_in   = sum_ff + SUM_W'(psq);
               count_in = count_ff + 1'b1;
            end
            if (kind_ff == rlm_pkg::KIND_MIC || kind_ff >= rlm_pkg::KIND_ALC) begin
               state_in = ST_EHI;
            end else begin
               state_in = ST_CHK;
            end
         end
         ST_EHI: begin
            state_in = ST_ELO;
         end
         // Decay term from the upper and lower halves of the average
         ST_ELO: begin
            dec_in   = EMA_W'(prod_ff) << (rlm_pkg::EMA_SPLIT - rlm_pkg::EMA_FRAC_BITS);
            state_in = ST_EPC;
         end
         ST_EPC: begin
            dec_in   = dec_ff + EMA_W'(prod_ff >>> rlm_pkg::EMA_FRAC_BITS);
            state_in = ST_EUPD;
         end
         ST_EUPD: begin
            ema_in[ema_idx] = ema_cur - dec_ff + EMA_W'(prod_ff);
            state_in        = ST_CHK;
         end
         ST_CHK: begin
            rd_in    = 1'b0;
            state_in = last_ff ? ST_LSEL : ST_IDLE;
         end
         // Dispatch one reading
         ST_LSEL: begin
            if (desc.src == rlm_pkg::SRC_AVG) begin
               state_in = ST_AVG1;
            end else if (desc.src == rlm_pkg::SRC_DIV) begin
               if (count_ff == '0) begin
                  res_in   = '0;
                  state_in = ST_EMIT;
               end else begin
                  q_in     = sum_ff;
                  rem_in   = '0;
                  it_in    = '0;
                  state_in = ST_DIV;
               end
            end else if (src_val == '0) begin
               res_in   = 32'(desc.zero_val);
               state_in = ST_EMIT;
            end else begin
               v_in     = src_val;
               e_in     = E_W'(LV_W - 1);
               state_in = ST_NORM;
            end
         end
         // Leading-one search, one bit a cycle
         ST_NORM: begin
            if (v_ff[LV_W-1]) begin
               m_in     = v_ff[LV_W-1 -: rlm_pkg::MANT_W];
               f_in     = '0;
               it_in    = '0;
               state_in = ST_SQ;
            end else begin
               v_in = v_ff << 1;
               e_in = e_ff - 1'b1;
            end
         end
         ST_SQ: begin
            state_in = ST_SQW;
         end
         // One fraction bit of log2 per squaring
         ST_SQW: begin
            f_in  = {f_ff[14:0], t[31]};
            m_in  = t[31] ? t[31:1] : t[30:0];
            it_in = it_ff + 1'b1;
            state_in = (it_ff == IT_W'(rlm_pkg::LOG_FRAC - 1)) ? ST_DBM : ST_SQ;
         end
         ST_DBM: begin
            d_in = $signed({2'b00, e_ff, f_ff})
                 - (D_W'(desc.scale) <<< rlm_pkg::LOG_FRAC);
            state_in = ST_DBK;
         end
         ST_DBK: begin
            state_in = ST_DBR;
         end
         // Scale to dB and round half up
         ST_DBR: begin
            res_in   = desc.neg ? -32'(r) : 32'(r);
            state_in = ST_EMIT;
         end
         ST_AVG1: begin
            state_in = ST_AVG2;
         end
         ST_AVG2: begin
            acc_in   = prod_ff;
            state_in = ST_AVG3;
         end
         // Strength average, rounded and clamped to 16 bits
         ST_AVG3: begin
            if (a > PROD_W'(32767)) begin
               avg_in = 16'sd32767;
            end else if (a < -PROD_W'(32768)) begin
               avg_in = -16'sd32768;
            end else begin
               avg_in = 16'(a);
            end
            res_in   = 32'(avg_in);
            state_in = ST_EMIT;
         end
         // Restoring divide of the power sum by the count
         ST_DIV: begin
            if (!diff[CNT_W+1]) begin
               rem_in = diff[CNT_W-1:0];
               q_in   = {q_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in = sh[CNT_W-1:0];
               q_in   = {q_ff[SUM_W-2:0], 1'b0};
            end
            it_in = it_ff + 1'b1;
            if (it_ff == IT_W'(SUM_W - 1)) begin
               res_in   = (|q_in[SUM_W-1:31]) ? 32'h7FFF_FFFF : {1'b0, q_in[30:0]};
               state_in = ST_EMIT;
            end
         end
         // Hand the reading to the output register
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = desc.id;
               rsp_value_in = res_ff;
               rsp_last_in  = desc.is_last;
               if (desc.is_last) begin
                  peak_i_in = '0;
                  peak_q_in = '0;
                  sum_in    = '0;
                  count_in  = '0;
                  state_in  = ST_IDLE;
               end else begin
                  rd_in    = 1'b1;
                  state_in = ST_LSEL;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and meter state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         peak_i_ff    <= '0;
         peak_q_ff    <= '0;
         sum_ff       <= '0;
         count_ff     <= '0;
         avg_ff       <= rlm_pkg::AVG_DB_RST;
         ema_ff       <= '{default: '0};
         rx_coef_ff   <= rlm_pkg::RX_AVG_COEF_RST;
         tx_coef_ff   <= rlm_pkg::TX_EMA_COEF_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         peak_i_ff    <= peak_i_in;
         peak_q_ff    <= peak_q_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         avg_ff       <= avg_in;
         ema_ff       <= ema_in;
         if (csr_we && csr_addr == rlm_pkg::CSR_RX_AVG_COEF) rx_coef_ff <= csr_wdata;
         if (csr_we && csr_addr == rlm_pkg::CSR_TX_EMA_COEF) tx_coef_ff <= csr_wdata;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      last_ff      <= last_in;
      ar_ff        <= ar_in;
      ai_ff        <= ai_in;
      gain_ff      <= gain_in;
      p_ff         <= p_in;
      dec_ff       <= dec_in;
      acc_ff       <= acc_in;
      v_ff         <= v_in;
      e_ff         <= e_in;
      m_ff         <= m_in;
      f_ff         <= f_in;
      it_ff        <= it_in;
      d_ff         <= d_in;
      res_ff       <= res_in;
      rd_ff        <= rd_in;
      rem_ff       <= rem_in;
      q_ff         <= q_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_id_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: hw/rtl/rlm_mul.sv
// ----------------------------------------------------------------------------
// Radio level meter shared multiplier
// Signed multiplier with a registered product, shared by the squaring, average and dB scaling steps.
// ----------------------------------------------------------------------------
module rlm_mul (
   input  logic                                clock,
   input  logic signed [rlm_pkg::MUL_W-1:0]    mul_a,
   input  logic signed [rlm_pkg::MUL_W-1:0]    mul_b,
   output logic signed [rlm_pkg::PROD_W-1:0]   prod_ff
);

   logic signed [rlm_pkg::PROD_W-1:0] prod_in;

   // Full-width product, registered once
   assign prod_in = rlm_pkg::PROD_W'(mul_a) * rlm_pkg::PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule
